>>> sv/surp_pkg.sv
// Shared types and constants for the sensor UART response parser.
`default_nettype none
package surp_pkg;

  localparam logic [1:0] OP_BYTE    = 2'd0;
  localparam logic [1:0] OP_TICK    = 2'd1;
  localparam logic [1:0] OP_REQUEST = 2'd2;

  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_EULER = 2'd1;
  localparam logic [1:0] KIND_CALIB = 2'd2;
  localparam logic [1:0] KIND_BAD   = 2'd3;

  localparam logic [1:0] RES_ACK   = 2'd0;
  localparam logic [1:0] RES_EULER = 2'd1;
  localparam logic [1:0] RES_CALIB = 2'd2;
  localparam logic [1:0] RES_RAW   = 2'd3;

  localparam logic [7:0] SYNC_ACK  = 8'hEE;
  localparam logic [7:0] SYNC_DATA = 8'hBB;

  localparam logic [7:0] TIMEOUT_RST = 8'd10;

  localparam int STORE_DEPTH = 6;
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] rx_byte;
    logic [1:0] request_kind;
  } in_item_t;

  typedef struct packed {
    logic [1:0]        result_kind;
    logic [7:0]        ack_status;
    logic [7:0]        first_payload_byte;
    logic signed [15:0] roll_angle;
    logic signed [15:0] pitch_angle;
    logic signed [15:0] yaw_angle;
    logic [1:0]        mag_calibration;
    logic [1:0]        accel_calibration;
    logic [1:0]        gyro_calibration;
    logic [1:0]        system_calibration;
  } out_item_t;

  typedef logic [STORE_DEPTH-1:0][7:0] payload_t;

  // Completed frame handed from parser to decoder
  typedef struct packed {
    logic       is_ack;
    logic [7:0] status;
    logic [1:0] kind;
    payload_t   bytes;
  } frame_ev_t;

  typedef struct packed {
    logic full;
  } q_stat_t;

endpackage
`default_nettype wire

>>> sv/surp_front.sv
// Frame parser: accepts bytes, ticks and request events, emits completed frames.
`default_nettype none
module surp_front (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  input  wire surp_pkg::in_item_t  in_data,
  input  wire surp_pkg::q_stat_t   q_stat,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data,
  output logic                     full,
  output logic                     ev_push,
  output surp_pkg::frame_ev_t      ev_data
);
  import surp_pkg::*;

  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_HEADER  = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;

  logic [1:0] phase_r, phase_nxt;
  logic       is_data_r, is_data_nxt;
  logic [7:0] frame_length_r, frame_length_nxt;
  logic [7:0] byte_count_r, byte_count_nxt;
  logic [7:0] elapsed_r, elapsed_nxt;
  logic [1:0] pending_r, pending_nxt;
  logic [7:0] timeout_r;
  payload_t   payload_r, payload_nxt;
  logic       accept;
  logic [1:0] phase_eff;
  logic [7:0] count_inc;
  logic [7:0] c;

  assign full   = q_stat.full;
  assign accept = push && !full;
  assign c      = in_data.rx_byte;

  always_comb begin
    phase_nxt        = phase_r;
    is_data_nxt      = is_data_r;
    frame_length_nxt = frame_length_r;
    byte_count_nxt   = byte_count_r;
    elapsed_nxt      = elapsed_r;
    pending_nxt      = pending_r;
    payload_nxt      = payload_r;
    ev_push          = 1'b0;
    ev_data          = '0;
    phase_eff        = phase_r;
    count_inc        = (byte_count_r != 8'hFF) ? byte_count_r + 8'd1 : byte_count_r;

    if (accept) begin
      case (in_data.operation)
        OP_TICK: begin
          if (elapsed_r != 8'hFF) begin
            elapsed_nxt = elapsed_r + 8'd1;
          end
        end
        OP_REQUEST: begin
          phase_nxt   = PH_IDLE;
          pending_nxt = (in_data.request_kind == KIND_BAD) ? KIND_NONE : in_data.request_kind;
        end
        OP_BYTE: begin
          if (phase_r != PH_IDLE && elapsed_r > timeout_r) begin
            phase_eff = PH_IDLE;
          end
          phase_nxt = phase_eff;
          case (phase_eff)
            PH_IDLE: begin
              if (c == SYNC_ACK || c == SYNC_DATA) begin
                elapsed_nxt = '0;
                phase_nxt   = PH_HEADER;
                is_data_nxt = (c == SYNC_DATA);
              end
            end
            PH_HEADER: begin
              if (!is_data_r) begin
                payload_nxt[0] = c;
                phase_nxt      = PH_IDLE;
                ev_push        = 1'b1;
                ev_data.is_ack = 1'b1;
                ev_data.status = c;
              end else begin
                frame_length_nxt = c;
                byte_count_nxt   = '0;
                if (c == 8'd0) begin
                  phase_nxt     = PH_IDLE;
                  pending_nxt   = KIND_NONE;
                  ev_push       = 1'b1;
                  ev_data.kind  = pending_r;
                  ev_data.bytes = payload_r;
                end else begin
                  phase_nxt = PH_PAYLOAD;
                end
              end
            end
            PH_PAYLOAD: begin
              if (byte_count_r < 8'(STORE_DEPTH)) begin
                payload_nxt[byte_count_r[$clog2(STORE_DEPTH)-1:0]] = c;
              end
              byte_count_nxt = count_inc;
              if (count_inc == frame_length_r) begin
                phase_nxt     = PH_IDLE;
                pending_nxt   = KIND_NONE;
                ev_push       = 1'b1;
                ev_data.kind  = pending_r;
                ev_data.bytes = payload_nxt;
              end
            end
            default: begin
              phase_nxt = PH_IDLE;
            end
          endcase
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      is_data_r      <= 1'b0;
      frame_length_r <= '0;
      byte_count_r   <= '0;
      elapsed_r      <= '0;
      pending_r      <= KIND_NONE;
      payload_r      <= '0;
      timeout_r      <= TIMEOUT_RST;
    end else begin
      phase_r        <= phase_nxt;
      is_data_r      <= is_data_nxt;
      frame_length_r <= frame_length_nxt;
      byte_count_r   <= byte_count_nxt;
      elapsed_r      <= elapsed_nxt;
      pending_r      <= pending_nxt;
      payload_r      <= payload_nxt;
      if (cfg_wr_en) begin
        timeout_r <= cfg_wr_data;
      end
    end
  end

  a_payload_count: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> byte_count_r < frame_length_r)
    else $error("payload count reached frame length without completion");

  a_pending_legal: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r != KIND_BAD)
    else $error("illegal pending request kind");

  a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
    ev_push && !ev_data.is_ack |=> pending_r == KIND_NONE && phase_r == PH_IDLE)
    else $error("data frame completion did not clear pending kind");

endmodule
`default_nettype wire

>>> sv/surp_queue.sv
// Short frame queue between the parser and the decoder.
`default_nettype none
module surp_queue (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                wr_en,
  input  wire surp_pkg::frame_ev_t wr_data,
  input  wire logic                rd_en,
  output surp_pkg::q_stat_t        stat,
  output logic                     rd_valid,
  output surp_pkg::frame_ev_t      rd_data
);
  import surp_pkg::*;

  frame_ev_t                 mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]       wptr_r, wptr_nxt;
  logic [QUEUE_AW-1:0]       rptr_r, rptr_nxt;
  logic [QUEUE_AW:0]         count_r, count_nxt;
  logic                      do_wr, do_rd;

  assign stat.full = (count_r == (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign rd_valid  = (count_r != '0);
  assign rd_data   = mem_r[rptr_r];
  assign do_wr     = wr_en && !stat.full;
  assign do_rd     = rd_en && rd_valid;

  always_comb begin
    wptr_nxt  = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt  = do_rd ? rptr_r + 1'b1 : rptr_r;
    count_nxt = count_r + (QUEUE_AW+1)'(do_wr) - (QUEUE_AW+1)'(do_rd);
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r  <= '0;
      rptr_r  <= '0;
      count_r <= '0;
    end else begin
      wptr_r  <= wptr_nxt;
      rptr_r  <= rptr_nxt;
      count_r <= count_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QUEUE_AW+1)'(QUEUE_DEPTH))
    else $error("frame queue count out of range");

endmodule
`default_nettype wire

>>> sv/surp_back.sv
// Frame decoder with output register: angle scaling and calibration unpacking.
`default_nettype none
module surp_back (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                ev_valid,
  input  wire surp_pkg::frame_ev_t ev_data,
  output logic                     ev_pop,
  input  wire logic                pop,
  output logic                     empty,
  output surp_pkg::out_item_t      out_data
);
  import surp_pkg::*;

  out_item_t res_r, res_nxt;
  logic      valid_r, valid_nxt;
  logic      load;

  // x*5/8 truncated toward zero, optionally negated
  function automatic logic signed [15:0] scale_angle(input logic [7:0] lo,
                                                     input logic [7:0] hi,
                                                     input logic       neg);
    logic signed [18:0] p;
    logic signed [18:0] q;
    logic signed [15:0] s;
    p = 19'($signed({hi, lo}));
    p = (p <<< 2) + p;
    q = p[18] ? p + 19'sd7 : p;
    s = 16'(q >>> 3);
    return neg ? -s : s;
  endfunction

  assign load   = ev_valid && (!valid_r || pop);
  assign ev_pop = load;
  assign empty  = !valid_r;
  assign out_data = res_r;

  always_comb begin
    res_nxt   = '0;
    valid_nxt = valid_r;
    if (pop && valid_r) begin
      valid_nxt = 1'b0;
    end
    if (ev_data.is_ack) begin
      res_nxt.result_kind = RES_ACK;
      res_nxt.ack_status  = ev_data.status;
    end else begin
      res_nxt.first_payload_byte = ev_data.bytes[0];
      case (ev_data.kind)
        KIND_EULER: begin
          res_nxt.result_kind = RES_EULER;
          res_nxt.roll_angle  = scale_angle(ev_data.bytes[2], ev_data.bytes[3], 1'b0);
          res_nxt.pitch_angle = scale_angle(ev_data.bytes[4], ev_data.bytes[5], 1'b1);
          res_nxt.yaw_angle   = scale_angle(ev_data.bytes[0], ev_data.bytes[1], 1'b0);
        end
        KIND_CALIB: begin
          res_nxt.result_kind        = RES_CALIB;
          res_nxt.mag_calibration    = ev_data.bytes[0][1:0];
          res_nxt.accel_calibration  = ev_data.bytes[0][3:2];
          res_nxt.gyro_calibration   = ev_data.bytes[0][5:4];
          res_nxt.system_calibration = ev_data.bytes[0][7:6];
        end
        default: begin
          res_nxt.result_kind = RES_RAW;
        end
      endcase
    end
    if (load) begin
      valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop |=> valid_r && $stable(res_r))
    else $error("waiting result changed before it was taken");

endmodule
`default_nettype wire

>>> sv/sensor_uart_response_parser.sv
// Top level of the sensor UART response parser.
//
//  channel | direction | handshake          | payload
//  input   | in        | push / full        | in_data  (in_item_t)
//  result  | out       | empty / pop        | out_data (out_item_t)
//  config  | in        | cfg_wr_en          | cfg_wr_data (frame timeout, ms)
//
// One input transaction per cycle while full is low; a completed frame goes
// to the result port through parser, frame queue and decoder register.
// full follows the four-entry frame queue; it rises only while results back up.
// Synchronous active-low reset; the timeout register resets to 10 ms.
`default_nettype none
module sensor_uart_response_parser (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                push,
  output logic                     full,
  input  wire surp_pkg::in_item_t  in_data,
  output logic                     empty,
  input  wire logic                pop,
  output surp_pkg::out_item_t      out_data,
  input  wire logic                cfg_wr_en,
  input  wire logic [7:0]          cfg_wr_data
);
  import surp_pkg::*;

  q_stat_t   q_stat;
  logic      ev_push;
  frame_ev_t ev_wr;
  logic      ev_valid;
  frame_ev_t ev_rd;
  logic      ev_pop;

  surp_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .full        (full),
    .ev_push     (ev_push),
    .ev_data     (ev_wr)
  );

  surp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (ev_push),
    .wr_data  (ev_wr),
    .rd_en    (ev_pop),
    .stat     (q_stat),
    .rd_valid (ev_valid),
    .rd_data  (ev_rd)
  );

  surp_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .ev_valid (ev_valid),
    .ev_data  (ev_rd),
    .ev_pop   (ev_pop),
    .pop      (pop),
    .empty    (empty),
    .out_data (out_data)
  );

endmodule
`default_nettype wire
